// File: hdl/tbss_pkg.sv
`timescale 1ns / 1ps
package tbss_pkg;

    // field and state widths
    localparam int TIME_BITS = 48;
    localparam int FRAC_BITS = 24;
    localparam int RATE_W    = 32;
    localparam int LAT_W     = 32;
    localparam int BURST_W   = 32;
    localparam int BYTES_W   = 32;
    localparam int OUT_W     = 48;
    localparam int CFG_IDX_W = 2;

    // bucket capacity in Q(BURST_W).FRAC_BITS bytes
    localparam int CAP_W  = BURST_W + FRAC_BITS;
    // deficit delay, quotient plus round up
    localparam int DLY_W  = CAP_W + 1;
    localparam int CMP_W  = (DLY_W > OUT_W) ? DLY_W : OUT_W;
    // shared adder width, covers 2*cap + elapsed and now + delay
    localparam int UNIT_W = ((CAP_W > TIME_BITS) ? CAP_W : TIME_BITS) + 2;
    localparam int CNT_W  = $clog2((CAP_W > RATE_W) ? CAP_W : RATE_W);
    localparam int RIDX_W = $clog2(RATE_W);

    localparam logic [BURST_W-1:0]   DEFAULT_BURST = BURST_W'(262144);
    localparam logic [TIME_BITS-1:0] TIME_MAX      = {TIME_BITS{1'b1}};
    localparam logic [OUT_W-1:0]     OUT_MAX       = {OUT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE    = 2'd0,
        CFG_LATENCY = 2'd1,
        CFG_BURST   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_MAC = 2'd0,
        OP_DIV = 2'd1,
        OP_ADD = 2'd2,
        OP_SUB = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_MAC,
        ST_FILL,
        ST_TAKE,
        ST_SUBTOK,
        ST_DIV,
        ST_ROUND,
        ST_LAST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [LAT_W-1:0]  latency;
        logic [CAP_W-1:0]  cap;
        logic              wr;
    } cfg_t;

endpackage

// File: hdl/token_bucket_send_shaper.sv
`timescale 1ns / 1ps
`default_nettype none
// Token bucket send shaper. Each input beat is one send request (time stamp in ns, byte count,
// internet-socket flag); each produces exactly one output beat with the bandwidth delay, the
// fixed latency delay and a shaped flag. One item is processed at a time and in_ready is low
// while it runs; a finished result sits in an output register, so the next request can be taken
// while that beat still waits. An unshaped request or a zero rate goes straight to the output; a
// shaped request may first run a 32-step shift-add refill multiply of elapsed time by rate, and
// on a deficit a 56-step restoring division of the deficit by the rate follows. Both loops run
// on one shared adder/subtractor. Configuration writes are always taken (cfg_ready is tied high),
// must only happen while the block is idle, and every write to a known register re-primes the
// bucket to full on the next shaped request with a non-zero rate. Rates are unsigned Q8.24 bytes
// per ns.
module token_bucket_send_shaper (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [tbss_pkg::TIME_BITS-1:0] now_ns,
    input  wire logic [tbss_pkg::BYTES_W-1:0]   byte_count,
    input  wire logic                           to_inet_socket,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tbss_pkg::OUT_W-1:0]          bandwidth_delay_ns,
    output logic [tbss_pkg::LAT_W-1:0]          latency_delay_ns,
    output logic                                shaped,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tbss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);
    import tbss_pkg::*;

    cfg_t cfg;

    // sequencer and bucket state
    state_t             state_reg, state_next;
    logic               primed_reg, primed_next;
    logic [CAP_W-1:0]   token_reg, token_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               sat_reg, sat_next;
    logic               shp_reg, shp_next;
    logic               out_valid_reg, out_valid_next;

    // per-item working registers
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CAP_W-1:0]     need_reg, need_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [CAP_W-1:0]     acc_reg, acc_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [CAP_W-1:0]     quo_reg, quo_next;
    logic [DLY_W-1:0]     delay_reg, delay_next;
    logic [OUT_W-1:0]     bw_reg, bw_next;
    logic [LAT_W-1:0]     lat_reg, lat_next;
    logic                 shaped_reg, shaped_next;

    // shared unit hookup
    op_t               u_op;
    logic [UNIT_W-1:0] u_x;
    logic [UNIT_W-1:0] u_y;
    logic              u_bit;
    logic [UNIT_W-1:0] u_sum;
    logic              u_carry;

    logic in_beat;
    logic out_free;
    logic req_shaped;
    logic go_bucket;
    logic sum_zero;

    tbss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbss_step_unit u_step (
        .op     (u_op),
        .x      (u_x),
        .y      (u_y),
        .bit_in (u_bit),
        .sum    (u_sum),
        .carry  (u_carry)
    );

    assign in_beat    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    // block enabled, non-empty request to an internet socket
    assign req_shaped = ((cfg.rate != '0) || (cfg.latency != '0))
                        && (byte_count != '0) && to_inet_socket;
    assign go_bucket  = req_shaped && (cfg.rate != '0);
    assign sum_zero   = (u_sum == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!go_bucket)
                        state_next = ST_DONE;
                    else if (primed_reg)
                        state_next = ST_ELAPSED;
                    else
                        state_next = ST_TAKE;  // just primed, no time to refill over
                end
            end
            ST_ELAPSED:
            begin
                // refill only when time has moved forward
                if (u_carry && !sum_zero)
                    state_next = ST_MAC;
                else
                    state_next = ST_TAKE;
            end
            ST_MAC:
            begin
                if (cnt_reg == '0)
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                state_next = ST_TAKE;
            end
            ST_TAKE:
            begin
                if (!u_carry)
                    state_next = ST_SUBTOK;
                else if (sum_zero)
                    state_next = ST_DONE;
                else
                    state_next = ST_DIV;
            end
            ST_SUBTOK:
            begin
                state_next = ST_DONE;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: handshake and shared unit operands
    always_comb
    begin
        in_ready = 1'b0;
        u_op     = OP_ADD;
        u_x      = '0;
        u_y      = '0;
        u_bit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_ELAPSED:
            begin
                u_op = OP_SUB;
                u_x  = UNIT_W'(now_reg);
                u_y  = UNIT_W'(last_reg);
            end
            ST_MAC:
            begin
                // msb-first shift-add of elapsed * rate
                u_op  = OP_MAC;
                u_x   = UNIT_W'(acc_reg);
                u_y   = UNIT_W'(elapsed_reg);
                u_bit = cfg.rate[cnt_reg[RIDX_W-1:0]];
            end
            ST_FILL:
            begin
                u_op = OP_ADD;
                u_x  = UNIT_W'(token_reg);
                u_y  = UNIT_W'(acc_reg);
            end
            ST_TAKE:
            begin
                u_op = OP_SUB;
                u_x  = UNIT_W'(need_reg);
                u_y  = UNIT_W'(token_reg);
            end
            ST_SUBTOK:
            begin
                u_op = OP_SUB;
                u_x  = UNIT_W'(token_reg);
                u_y  = UNIT_W'(need_reg);
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                u_op  = OP_DIV;
                u_x   = UNIT_W'(rem_reg);
                u_y   = UNIT_W'(cfg.rate);
                u_bit = quo_reg[CAP_W-1];
            end
            ST_ROUND:
            begin
                // round the quotient up on a non-zero remainder
                u_op = OP_ADD;
                u_x  = UNIT_W'(quo_reg);
                u_y  = UNIT_W'(rem_reg != '0);
            end
            ST_LAST:
            begin
                u_op = OP_ADD;
                u_x  = UNIT_W'(now_reg);
                u_y  = UNIT_W'(delay_reg);
            end
            ST_DONE:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        primed_next    = primed_reg;
        token_next     = token_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        shp_next       = shp_reg;
        now_next       = now_reg;
        need_next      = need_reg;
        elapsed_next   = elapsed_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        delay_next     = delay_reg;
        bw_next        = bw_reg;
        lat_next       = lat_reg;
        shaped_next    = shaped_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg.wr)
            primed_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    now_next   = now_ns;
                    need_next  = CAP_W'(byte_count) << FRAC_BITS;
                    shp_next   = req_shaped;
                    delay_next = '0;
                    if (go_bucket && !primed_reg)
                    begin
                        // first shaped request fills the bucket to burst
                        primed_next = 1'b1;
                        token_next  = cfg.cap;
                        last_next   = now_ns;
                    end
                end
            end
            ST_ELAPSED:
            begin
                elapsed_next = u_sum[TIME_BITS-1:0];
                acc_next     = '0;
                sat_next     = 1'b0;
                cnt_next     = CNT_W'(RATE_W - 1);
            end
            ST_MAC:
            begin
                // once the partial product passes the cap the refill is full anyway
                if (!sat_reg)
                begin
                    if (u_sum > UNIT_W'(cfg.cap))
                        sat_next = 1'b1;
                    else
                        acc_next = u_sum[CAP_W-1:0];
                end
                cnt_next = cnt_reg - 1'b1;
            end
            ST_FILL:
            begin
                last_next = now_reg;
                if (sat_reg || (u_sum >= UNIT_W'(cfg.cap)))
                    token_next = cfg.cap;
                else
                    token_next = u_sum[CAP_W-1:0];
            end
            ST_TAKE:
            begin
                if (u_carry)
                begin
                    if (sum_zero)
                    begin
                        token_next = '0;
                    end
                    else
                    begin
                        // deficit goes into the dividend shift register
                        quo_next = u_sum[CAP_W-1:0];
                        rem_next = '0;
                        cnt_next = CNT_W'(CAP_W - 1);
                    end
                end
            end
            ST_SUBTOK:
            begin
                token_next = u_sum[CAP_W-1:0];
            end
            ST_DIV:
            begin
                if (u_carry)
                    rem_next = u_sum[RATE_W-1:0];
                else
                    rem_next = {rem_reg[RATE_W-2:0], quo_reg[CAP_W-1]};
                quo_next = {quo_reg[CAP_W-2:0], u_carry};
                cnt_next = cnt_reg - 1'b1;
            end
            ST_ROUND:
            begin
                delay_next = u_sum[DLY_W-1:0];
            end
            ST_LAST:
            begin
                token_next = '0;
                if (u_sum > UNIT_W'(TIME_MAX))
                    last_next = TIME_MAX;
                else
                    last_next = u_sum[TIME_BITS-1:0];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (!shp_reg)
                        bw_next = '0;
                    else if (CMP_W'(delay_reg) > CMP_W'(OUT_MAX))
                        bw_next = OUT_MAX;
                    else
                        bw_next = OUT_W'(delay_reg);
                    lat_next    = shp_reg ? cfg.latency : '0;
                    shaped_next = shp_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            token_reg     <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            shp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            token_reg     <= token_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
            shp_reg       <= shp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        need_reg    <= need_next;
        elapsed_reg <= elapsed_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        delay_reg   <= delay_next;
        bw_reg      <= bw_next;
        lat_reg     <= lat_next;
        shaped_reg  <= shaped_next;
    end

    assign out_valid          = out_valid_reg;
    assign bandwidth_delay_ns = bw_reg;
    assign latency_delay_ns   = lat_reg;
    assign shaped             = shaped_reg;

    // a known register write forces re-priming
    a_cfg_unprime : assert property (@(posedge clk) disable iff (!rst_n)
        cfg.wr |=> !primed_reg)
        else $error("configuration write did not clear primed");

    // unshaped beats carry no delay at all
    a_unshaped_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !shaped) |-> (bandwidth_delay_ns == '0 && latency_delay_ns == '0))
        else $error("unshaped result carries a delay");

    // restoring divide keeps the partial remainder below the divisor
    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < cfg.rate))
        else $error("divider remainder out of range");

    // a deficit always drains the bucket
    a_deficit_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAST) |=> (token_reg == '0))
        else $error("bucket not empty after deficit");

    // no new request while a result is still being built
    a_busy_no_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_MAC) |=> !in_beat || state_reg == ST_IDLE)
        else $error("request taken while busy");

endmodule
`default_nettype wire

// File: hdl/tbss_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module tbss_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tbss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data,
    output tbss_pkg::cfg_t                      cfg
);
    import tbss_pkg::*;

    logic [RATE_W-1:0]  rate_reg,    rate_next;
    logic [LAT_W-1:0]   latency_reg, latency_next;
    logic [BURST_W-1:0] burst_reg,   burst_next;
    logic               wr_hit;
    logic [BURST_W-1:0] burst_eff;

    assign cfg_ready = 1'b1;

    // register decode
    always_comb
    begin
        rate_next    = rate_reg;
        latency_next = latency_reg;
        burst_next   = burst_reg;
        wr_hit       = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RATE:
                begin
                    rate_next = cfg_data[RATE_W-1:0];
                    wr_hit    = 1'b1;
                end
                CFG_LATENCY:
                begin
                    latency_next = cfg_data[LAT_W-1:0];
                    wr_hit       = 1'b1;
                end
                CFG_BURST:
                begin
                    burst_next = cfg_data[BURST_W-1:0];
                    wr_hit     = 1'b1;
                end
                default:
                begin
                    wr_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= '0;
            latency_reg <= '0;
            burst_reg   <= DEFAULT_BURST;
        end
        else
        begin
            rate_reg    <= rate_next;
            latency_reg <= latency_next;
            burst_reg   <= burst_next;
        end
    end

    // zero burst acts as the default capacity
    assign burst_eff   = (burst_reg == '0) ? DEFAULT_BURST : burst_reg;
    assign cfg.rate    = rate_reg;
    assign cfg.latency = latency_reg;
    assign cfg.cap     = {burst_eff, {FRAC_BITS{1'b0}}};
    assign cfg.wr      = wr_hit;

endmodule
`default_nettype wire

// File: hdl/tbss_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tbss_step_unit (
    input  wire tbss_pkg::op_t               op,
    input  wire logic [tbss_pkg::UNIT_W-1:0] x,
    input  wire logic [tbss_pkg::UNIT_W-1:0] y,
    input  wire logic                        bit_in,
    output logic [tbss_pkg::UNIT_W-1:0]      sum,
    output logic                             carry
);
    import tbss_pkg::*;

    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
    logic              sub;
    logic [UNIT_W:0]   wide;

    // operand forming: shift-add step, restoring divide step, plain add or subtract
    always_comb
    begin
        a   = x;
        b   = y;
        sub = 1'b0;
        unique case (op)
            OP_MAC:
            begin
                a   = {x[UNIT_W-2:0], 1'b0};
                b   = bit_in ? y : '0;
                sub = 1'b0;
            end
            OP_DIV:
            begin
                a   = {x[UNIT_W-2:0], bit_in};
                b   = y;
                sub = 1'b1;
            end
            OP_ADD:
            begin
                a   = x;
                b   = y;
                sub = 1'b0;
            end
            OP_SUB:
            begin
                a   = x;
                b   = y;
                sub = 1'b1;
            end
            default:
            begin
                a   = x;
                b   = y;
                sub = 1'b0;
            end
        endcase
    end

    // carry high on subtract means a >= b
    assign wide  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (UNIT_W+1)'(sub);
    assign sum   = wide[UNIT_W-1:0];
    assign carry = wide[UNIT_W];

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

import tbss_pkg::*;

typedef struct packed {
    logic [TIME_BITS-1:0] now;
    logic [BYTES_W-1:0]   nbytes;
    logic                 inet;
} send_req_t;

typedef struct packed {
    logic [OUT_W-1:0] bw_delay;
    logic [LAT_W-1:0] lat_delay;
    logic             shaped;
} shape_res_t;

// bucket predictor plus queue of expected result beats
class shaper_scoreboard;
    logic [RATE_W-1:0]    rate;
    logic [LAT_W-1:0]     latency;
    logic [BURST_W-1:0]   burst;
    logic [CAP_W-1:0]     tokens;
    logic [TIME_BITS-1:0] refill_at;
    bit                   primed;
    shape_res_t           expected_q[$];
    shape_res_t           last_expected;
    int                   errors;

    function new();
        rate          = '0;
        latency       = '0;
        burst         = DEFAULT_BURST;
        tokens        = '0;
        refill_at     = '0;
        primed        = 1'b0;
        last_expected = '0;
        errors        = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            CFG_RATE:    rate = data;
            CFG_LATENCY: latency = data;
            CFG_BURST:   burst = data;
            default:     return;
        endcase
        primed = 1'b0;
    endfunction

    function shape_res_t shape(send_req_t r);
        shape_res_t res;
        logic [63:0] cap, need, elapsed, fill_limit, add, deficit, dly;
        res = '0;
        dly = '0;
        if ((rate == 0 && latency == 0) || r.nbytes == 0 || !r.inet)
            return res;
        if (rate != 0)
        begin
            cap  = 64'((burst == 0) ? DEFAULT_BURST : burst) << FRAC_BITS;
            need = 64'(r.nbytes) << FRAC_BITS;
            if (!primed)
            begin
                primed    = 1'b1;
                tokens    = cap[CAP_W-1:0];
                refill_at = r.now;
            end
            // refill only when time moved forward
            if (r.now > refill_at)
            begin
                elapsed    = 64'(r.now) - 64'(refill_at);
                fill_limit = cap / 64'(rate);
                if (elapsed > fill_limit || 64'(tokens) >= cap)
                    tokens = cap[CAP_W-1:0];
                else
                begin
                    add = elapsed * 64'(rate);
                    if (add >= cap - 64'(tokens))
                        tokens = cap[CAP_W-1:0];
                    else
                        tokens = tokens + add[CAP_W-1:0];
                end
                refill_at = r.now;
            end
            if (need <= 64'(tokens))
                tokens = tokens - need[CAP_W-1:0];
            else
            begin
                deficit = need - 64'(tokens);
                dly     = deficit / 64'(rate);
                if (deficit % 64'(rate) != 0)
                    dly = dly + 1;
                tokens = '0;
                if (dly > 64'(TIME_MAX) - 64'(r.now))
                    refill_at = TIME_MAX;
                else
                    refill_at = TIME_BITS'(64'(r.now) + dly);
            end
        end
        res.bw_delay  = (dly > 64'(OUT_MAX)) ? OUT_MAX : dly[OUT_W-1:0];
        res.lat_delay = latency;
        res.shaped    = 1'b1;
        return res;
    endfunction

    function void note_request(send_req_t r);
        last_expected = shape(r);
        expected_q.push_back(last_expected);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(string msg);
        if (errors < 40)
            $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(shape_res_t got);
        shape_res_t exp_res;
        if (expected_q.size() == 0)
        begin
            report($sformatf("result beat with nothing outstanding: bw=%0d lat=%0d shaped=%0b",
                             got.bw_delay, got.lat_delay, got.shaped));
            return;
        end
        exp_res = expected_q.pop_front();
        if (got.bw_delay != exp_res.bw_delay)
            report($sformatf("bandwidth_delay_ns got %0d want %0d",
                             got.bw_delay, exp_res.bw_delay));
        if (got.lat_delay != exp_res.lat_delay)
            report($sformatf("latency_delay_ns got %0d want %0d",
                             got.lat_delay, exp_res.lat_delay));
        if (got.shaped != exp_res.shaped)
            report($sformatf("shaped got %0b want %0b", got.shaped, exp_res.shaped));
    endtask
endclass

module tb;

    // register index past the last one, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // one byte per ns in q8.24
    localparam logic [RATE_W-1:0] RATE_ONE = 32'h0100_0000;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SEGMENTS    = 5;
    localparam int SEG_ITEMS   = 100;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic [TIME_BITS-1:0] now_ns         = '0;
    logic [BYTES_W-1:0]   byte_count     = '0;
    logic                 to_inet_socket = 1'b0;

    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic [OUT_W-1:0]     bandwidth_delay_ns;
    logic [LAT_W-1:0]     latency_delay_ns;
    logic                 shaped;

    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [31:0]          cfg_data       = '0;

    // idle percentages for the request and result sides
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    shaper_scoreboard sb = new();

    always #4 clk = ~clk;

    token_bucket_send_shaper i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .now_ns             (now_ns),
        .byte_count         (byte_count),
        .to_inet_socket     (to_inet_socket),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .bandwidth_delay_ns (bandwidth_delay_ns),
        .latency_delay_ns   (latency_delay_ns),
        .shaped             (shaped),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // watchdog, covers a hung handshake anywhere in the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check a beat taken at this edge, then pick ready for the next cycle
    always @(posedge clk)
    begin : result_sink
        shape_res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.bw_delay  = bandwidth_delay_ns;
            got.lat_delay = latency_delay_ns;
            got.shaped    = shaped;
            sb.check_result(got);
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // one request beat, random gaps before it, valid held until taken
    task send_req(input send_req_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        now_ns         <= r.now;
        byte_count     <= r.nbytes;
        to_inet_socket <= r.inet;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task send_one(input logic [TIME_BITS-1:0] t, input logic [BYTES_W-1:0] n, input logic inet);
        send_req_t r;
        r.now    = t;
        r.nbytes = n;
        r.inet   = inet;
        send_req(r);
    endtask

    // stop sending and hold off until every result beat is back
    task wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.apply_write(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        send_req_t            req;
        logic [TIME_BITS-1:0] clock_ns;
        logic [RATE_W-1:0]    new_rate;
        logic [LAT_W-1:0]     new_lat;
        logic [BURST_W-1:0]   new_burst;
        logic [BURST_W-1:0]   burst_eff;
        logic [31:0]          step;
        int                   pick;

        send_idle_pct = 28;
        recv_idle_pct = 52;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: rate and latency zero, block disabled
        send_one(48'd5, 32'd100, 1'b1);
        send_one(TIME_MAX, 32'hFFFF_FFFF, 1'b1);

        // one byte per ns, small bucket
        wait_idle();
        write_reg(CFG_RATE, RATE_ONE);
        write_reg(CFG_LATENCY, 32'd100);
        write_reg(CFG_BURST, 32'd1000);
        send_one(48'd900, 32'd0, 1'b1);                 // empty send passes through
        send_one(48'd900, 32'd10, 1'b0);                // non-inet socket passes through
        send_one(48'd1000, 32'd500, 1'b1);              // primes bucket, takes 500
        send_one(48'd1000, 32'd600, 1'b1);              // same time, deficit of 100
        send_one(48'd1050, 32'd10, 1'b1);               // behind refill time, no refill
        send_one(48'd1_000_000, 32'd10, 1'b1);          // long idle clamps at burst
        send_one(48'd1_000_300, 32'd400, 1'b1);         // refill tops the bucket up to burst
        send_one(48'd2_000_000, 32'hFFFF_FFFF, 1'b1);   // largest request
        send_one(TIME_MAX - 48'd5, 32'd2000, 1'b1);     // refill time saturates
        send_one(48'd0, 32'd1, 1'b1);                   // time went backwards

        // fastest rate, largest latency, zero burst means default size
        wait_idle();
        write_reg(CFG_BURST, 32'd0);
        write_reg(CFG_RATE, 32'hFFFF_FFFF);
        write_reg(CFG_LATENCY, 32'hFFFF_FFFF);
        send_one(48'd10, 32'd300_000, 1'b1);
        send_one(48'd20, 32'd262_144, 1'b1);

        // slowest rate, largest bucket: delay beyond the output range saturates
        wait_idle();
        write_reg(CFG_RATE, 32'd1);
        write_reg(CFG_BURST, 32'hFFFF_FFFF);
        send_one(48'd100, 32'hFFFF_FFFF, 1'b1);
        send_one(48'd100, 32'hFFFF_FFFF, 1'b1);
        send_one(48'd200, 32'd1, 1'b1);

        // latency only, no bandwidth shaping
        wait_idle();
        write_reg(CFG_RATE, 32'd0);
        write_reg(CFG_LATENCY, 32'd777);
        send_one(48'd50, 32'd100, 1'b1);
        send_one(48'd60, 32'd0, 1'b1);

        // write to the spare index must not re-prime the bucket
        wait_idle();
        write_reg(CFG_RATE, RATE_ONE);
        write_reg(CFG_LATENCY, 32'd0);
        write_reg(CFG_BURST, 32'd1000);
        send_one(48'd100, 32'd900, 1'b1);
        wait_idle();
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        send_one(48'd100, 32'd200, 1'b1);

        // random part, three idle modes, several settings in each
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 28;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                wait_idle();
                case ($urandom_range(0, 7))
                    0:       new_rate = '0;
                    1:       new_rate = $urandom_range(1, 255);
                    2:       new_rate = 32'hFFFF_FFFF;
                    3:       new_rate = $urandom;
                    default: new_rate = $urandom_range(32'h0010_0000, 32'h1000_0000);
                endcase
                case ($urandom_range(0, 3))
                    0:       new_lat = '0;
                    1:       new_lat = $urandom;
                    default: new_lat = $urandom_range(1, 10000);
                endcase
                case ($urandom_range(0, 5))
                    0:       new_burst = '0;
                    1:       new_burst = 32'hFFFF_FFFF;
                    2:       new_burst = $urandom;
                    default: new_burst = $urandom_range(1, 100000);
                endcase
                write_reg(CFG_RATE, new_rate);
                write_reg(CFG_LATENCY, new_lat);
                write_reg(CFG_BURST, new_burst);
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_SPARE, $urandom);
                burst_eff = (new_burst == 0) ? DEFAULT_BURST : new_burst;
                clock_ns  = TIME_BITS'({$urandom, $urandom});

                for (int k = 0; k < SEG_ITEMS; k++)
                begin
                    // hold off mid-segment until the block has drained
                    if (seg == 2 && k == SEG_ITEMS / 2)
                        wait_idle();
                    step     = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4000);
                    clock_ns = clock_ns + TIME_BITS'(step);
                    pick     = $urandom_range(0, 99);
                    req.now    = clock_ns;
                    req.inet   = 1'b1;
                    req.nbytes = $urandom_range(1, burst_eff / 4 + 1);
                    if (pick >= 95)
                        req.inet = 1'b0;
                    else if (pick >= 90)
                        req.nbytes = '0;
                    else if (pick >= 80)
                    begin
                        // noise: any time, any size, either socket kind
                        req.now    = TIME_BITS'({$urandom, $urandom});
                        req.nbytes = $urandom;
                        req.inet   = 1'($urandom_range(0, 1));
                    end
                    send_req(req);
                    // a well-behaved sender mostly waits out the delay it was given
                    if ($urandom_range(0, 3) != 0)
                        clock_ns = clock_ns + TIME_BITS'(sb.last_expected.bw_delay);
                end
            end
        end

        wait_idle();
        // stray beats after the last expected one still get caught
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/tbss_pkg.sv
hdl/tbss_cfg_regs.sv
hdl/tbss_step_unit.sv
hdl/token_bucket_send_shaper.sv
sim/tb.sv
